// ===== hw/rtl/scr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scr_pkg
// Shared types, constants and output helpers for the S-curve speed ramp.
// ----------------------------------------------------------------------------
package scr_pkg;

  localparam int DEF_TIME_WIDTH    = 32;
  localparam int DEF_FRACTION_BITS = 16;

  localparam logic [15:0] RAMP_MS_RESET = 16'd1000;
  // 100 percent in Q8.8
  localparam logic [15:0] FULL_SCALE    = 16'd25600;
  // floor(t / 100) == (t * 5243) >> 19 for t < 25600
  localparam logic [12:0] DIV100_MUL    = 13'd5243;
  localparam int          DIV100_SHIFT  = 19;

  typedef enum logic [1:0] {
    MODE_RELEASE  = 2'd0,
    MODE_FORWARD  = 2'd1,
    MODE_BACKWARD = 2'd2
  } drive_mode_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_DIVX_INIT,
    OP_DIV_STEP,
    OP_SQ,
    OP_SQRT_STEP,
    OP_DIVF_INIT,
    OP_MUL,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic stop;
    logic in_ramp;
  } dp_status_t;

  // |speed| * 255 / 25600, truncated, saturated at 255
  function automatic logic [7:0] duty_of(input logic [15:0] spd);
    logic [16:0] wide;
    logic [15:0] mag;
    logic [23:0] p;
    logic [28:0] prod;
    wide = {spd[15], spd};
    if (spd[15]) begin
      wide = 17'd0 - wide;
    end
    mag  = wide[15:0];
    p    = {mag, 8'd0} - {8'd0, mag};
    prod = 29'(p[23:8]) * 29'(DIV100_MUL);
    if (mag >= FULL_SCALE) begin
      duty_of = 8'hFF;
    end else begin
      duty_of = 8'(prod >> DIV100_SHIFT);
    end
  endfunction

  function automatic drive_mode_t mode_of(input logic [15:0] spd);
    if (spd[15]) begin
      mode_of = MODE_BACKWARD;
    end else if (spd != 16'd0) begin
      mode_of = MODE_FORWARD;
    end else begin
      mode_of = MODE_RELEASE;
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/scr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scr_ctrl
// Sequencer: steps the datapath through divide, root, divide and multiply.
// ----------------------------------------------------------------------------
module scr_ctrl #(
  parameter int FRACTION_BITS = scr_pkg::DEF_FRACTION_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  scr_pkg::dp_status_t stat,
  output scr_pkg::dp_cmd_t    cmd
);

  localparam int CW = $clog2(FRACTION_BITS + 3);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DIVX, S_SQ, S_SQRT, S_DIVF_INIT, S_DIVF, S_MUL, S_FINISH
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;
  logic          out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.op = scr_pkg::OP_IDLE;
    unique case (state)
      S_IDLE:      cmd.op = (in_valid) ? scr_pkg::OP_LOAD : scr_pkg::OP_IDLE;
      S_CHECK:     cmd.op = (!stat.stop && stat.in_ramp) ? scr_pkg::OP_DIVX_INIT
                                                         : scr_pkg::OP_IDLE;
      S_DIVX:      cmd.op = scr_pkg::OP_DIV_STEP;
      S_SQ:        cmd.op = scr_pkg::OP_SQ;
      S_SQRT:      cmd.op = scr_pkg::OP_SQRT_STEP;
      S_DIVF_INIT: cmd.op = scr_pkg::OP_DIVF_INIT;
      S_DIVF:      cmd.op = scr_pkg::OP_DIV_STEP;
      S_MUL:       cmd.op = scr_pkg::OP_MUL;
      S_FINISH:    cmd.op = out_free ? scr_pkg::OP_FINISH : scr_pkg::OP_IDLE;
      default:     cmd.op = scr_pkg::OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new result in the same cycle takes precedence over the clear
      if (out_ready && !((state == S_FINISH) && out_free)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (stat.stop || !stat.in_ramp) begin
            state <= S_FINISH;
          end else begin
            state <= S_DIVX;
            cnt   <= CW'(FRACTION_BITS - 1);
          end
        end
        S_DIVX: begin
          if (cnt == '0) begin
            state <= S_SQ;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_SQ: begin
          state <= S_SQRT;
          cnt   <= CW'(FRACTION_BITS + 2);
        end
        S_SQRT: begin
          if (cnt == '0) begin
            state <= S_DIVF_INIT;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_DIVF_INIT: begin
          state <= S_DIVF;
          cnt   <= CW'(FRACTION_BITS);
        end
        S_DIVF: begin
          if (cnt == '0) begin
            state <= S_MUL;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_MUL: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/scr_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scr_datapath
// Ramp state, shared restoring divider, digit-serial root, scaling multiply.
// ----------------------------------------------------------------------------
module scr_datapath #(
  parameter int TIME_WIDTH    = scr_pkg::DEF_TIME_WIDTH,
  parameter int FRACTION_BITS = scr_pkg::DEF_FRACTION_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  scr_pkg::dp_cmd_t       cmd,
  output scr_pkg::dp_status_t    stat,
  input  logic                   cfg_we,
  input  logic [15:0]            cfg_data,
  input  logic [TIME_WIDTH-1:0]  now_ms,
  input  logic [15:0]            speed_cmd,
  input  logic                   opcode,
  output logic [15:0]            present_speed,
  output logic [7:0]             pwm_duty,
  output logic [1:0]             drive_mode
);

  localparam int F  = FRACTION_BITS;
  localparam int DW = (F + 5 > 16) ? F + 5 : 16;
  localparam int SW = 2 * F + 6;
  localparam int RW = F + 3;
  localparam logic [F+2:0] FOUR = {1'b1, {(F+2){1'b0}}};
  localparam logic [SW-1:0] ONE_SQ = {{5{1'b0}}, 1'b1, {(2*F){1'b0}}};

  logic [15:0]           ramp_ms;
  logic [15:0]           goal_speed;
  logic [15:0]           ramp_start_speed;
  logic [15:0]           speed_now;
  logic [TIME_WIDTH-1:0] ramp_start_time;
  logic [TIME_WIDTH-1:0] now_q;
  logic                  stop_q;

  logic [DW-1:0]         rem_d;
  logic [DW-1:0]         div;
  logic [F:0]            quo;
  logic [SW-1:0]         sq_n;
  logic [RW-1:0]         rem_s;
  logic [RW-1:0]         root;
  logic [F+2:0]          au;
  logic                  u_neg;
  logic [F+16:0]         prod;
  logic                  d_neg;

  logic [TIME_WIDTH-1:0] elapsed;
  logic [DW:0]           div_t;
  logic                  div_ge;
  logic [F+2:0]          x8;
  logic                  x_neg;
  logic [F+2:0]          x_abs;
  logic [SW-1:0]         sq_full;
  logic [RW+1:0]         rem_sh;
  logic [RW+1:0]         trial;
  logic                  sq_ge;
  logic [F+3:0]          upd;
  logic [16:0]           diff;
  logic [15:0]           adiff;
  logic [15:0]           stepm;
  logic [15:0]           ramp_speed;
  logic [15:0]           sel_speed;

  assign elapsed      = now_q - ramp_start_time;
  assign stat.stop    = stop_q;
  assign stat.in_ramp = (ramp_ms != 16'd0) &&
                        (elapsed < TIME_WIDTH'(ramp_ms));

  assign div_t  = {rem_d, 1'b0};
  assign div_ge = div_t >= {1'b0, div};

  assign x8      = {quo[F-1:0], 3'b000};
  assign x_neg   = x8 < FOUR;
  assign x_abs   = x_neg ? (FOUR - x8) : (x8 - FOUR);
  assign sq_full = SW'(x_abs) * SW'(x_abs) + ONE_SQ;

  assign rem_sh = {rem_s, sq_n[SW-1:SW-2]};
  assign trial  = {root, 2'b01};
  assign sq_ge  = rem_sh >= trial;

  assign upd = u_neg ? ({1'b0, root} - {1'b0, au}) : ({1'b0, root} + {1'b0, au});

  assign diff  = {goal_speed[15], goal_speed} - {ramp_start_speed[15], ramp_start_speed};
  assign adiff = diff[16] ? 16'(17'd0 - diff) : diff[15:0];

  assign stepm      = prod[F+15:F];
  assign ramp_speed = d_neg ? (ramp_start_speed - stepm) : (ramp_start_speed + stepm);
  assign sel_speed  = stop_q       ? speed_now  :
                      stat.in_ramp ? ramp_speed : goal_speed;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_ms <= scr_pkg::RAMP_MS_RESET;
    end else if (cfg_we) begin
      ramp_ms <= cfg_data;
    end
  end

  // ramp state
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_speed       <= '0;
      ramp_start_speed <= '0;
      speed_now        <= '0;
      ramp_start_time  <= '0;
      stop_q           <= 1'b0;
    end else begin
      if (cmd.op == scr_pkg::OP_LOAD) begin
        stop_q <= opcode;
        if (!opcode && (speed_cmd != goal_speed)) begin
          goal_speed       <= speed_cmd;
          ramp_start_speed <= speed_now;
          ramp_start_time  <= now_ms;
        end
      end
      if ((cmd.op == scr_pkg::OP_FINISH) && !stop_q) begin
        speed_now <= sel_speed;
      end
    end
  end

  // arithmetic units and result
  always_ff @(posedge clk) begin
    case (cmd.op)
      scr_pkg::OP_LOAD: begin
        now_q <= now_ms;
      end
      scr_pkg::OP_DIVX_INIT: begin
        rem_d <= DW'(elapsed[15:0]);
        div   <= DW'(ramp_ms);
        quo   <= '0;
      end
      scr_pkg::OP_DIV_STEP: begin
        rem_d <= div_ge ? DW'(div_t - {1'b0, div}) : div_t[DW-1:0];
        quo   <= {quo[F-1:0], div_ge};
      end
      scr_pkg::OP_SQ: begin
        sq_n  <= sq_full;
        au    <= x_abs;
        u_neg <= x_neg;
        rem_s <= '0;
        root  <= '0;
      end
      scr_pkg::OP_SQRT_STEP: begin
        rem_s <= sq_ge ? RW'(rem_sh - trial) : rem_sh[RW-1:0];
        root  <= {root[RW-2:0], sq_ge};
        sq_n  <= {sq_n[SW-3:0], 2'b00};
      end
      scr_pkg::OP_DIVF_INIT: begin
        rem_d <= DW'(upd);
        div   <= DW'({root, 2'b00});
      end
      scr_pkg::OP_MUL: begin
        prod  <= (F+17)'(adiff) * (F+17)'(quo);
        d_neg <= diff[16];
      end
      scr_pkg::OP_FINISH: begin
        present_speed <= sel_speed;
        pwm_duty      <= stop_q ? 8'd0 : scr_pkg::duty_of(sel_speed);
        drive_mode    <= stop_q ? scr_pkg::MODE_RELEASE : scr_pkg::mode_of(sel_speed);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/s_curve_speed_ramp_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// s_curve_speed_ramp_core
// S-curve speed ramp with PWM duty and drive mode output.
// ----------------------------------------------------------------------------
// One input beat gives one output beat. A beat whose target differs from the
// stored goal restarts the ramp from the present speed at now_ms. Inside the
// ramp window the speed follows a smooth S profile from start to goal; after
// it (or with ramp_ms = 0) the speed equals the goal. An urgent stop beat
// returns the present speed with duty 0 and release, and changes nothing.
// A stop or settled beat goes from S_CHECK straight to S_FINISH; a beat inside
// the ramp first runs the shared bit-serial divider (used twice), the
// digit-serial square root and the multiply. S_FINISH waits while a result is
// stalled on out_ready. One beat is in work at a time; in_ready is high whenever the
// sequencer is idle, even while the previous result waits on out_ready.
// ramp_ms may be written only while the block is idle.
// ----------------------------------------------------------------------------
module s_curve_speed_ramp_core #(
  parameter int TIME_WIDTH    = scr_pkg::DEF_TIME_WIDTH,
  parameter int FRACTION_BITS = scr_pkg::DEF_FRACTION_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  // config
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_data,
  // input beat
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TIME_WIDTH-1:0] now_ms,
  input  logic signed [15:0]    speed_cmd,
  input  logic                  opcode,
  // output beat
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    present_speed,
  output logic [7:0]            pwm_duty,
  output logic [1:0]            drive_mode
);

  scr_pkg::dp_cmd_t    cmd;
  scr_pkg::dp_status_t stat;
  logic [15:0]         speed_bits;

  assign present_speed = signed'(speed_bits);

  scr_ctrl #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  scr_datapath #(
    .TIME_WIDTH    (TIME_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .now_ms        (now_ms),
    .speed_cmd     (unsigned'(speed_cmd)),
    .opcode        (opcode),
    .present_speed (speed_bits),
    .pwm_duty      (pwm_duty),
    .drive_mode    (drive_mode)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/scr_port_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scr_port_checker
// Port-level checks for the S-curve speed ramp, bound to the top level.
// ----------------------------------------------------------------------------
module scr_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] present_speed,
  input logic [7:0]  pwm_duty,
  input logic [1:0]  drive_mode
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(present_speed) &&
                                $stable(pwm_duty) && $stable(drive_mode))
    else $error("output beat changed while stalled");

  // one beat in work at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // release means no drive
  a_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && (drive_mode == scr_pkg::MODE_RELEASE) |-> pwm_duty == 8'd0)
    else $error("duty nonzero in release");

  // forward only for positive speed, never the unused code
  a_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((drive_mode == scr_pkg::MODE_RELEASE) ||
                   (drive_mode == scr_pkg::MODE_FORWARD) ||
                   (drive_mode == scr_pkg::MODE_BACKWARD)) &&
                  ((drive_mode != scr_pkg::MODE_FORWARD) ||
                   (!present_speed[15] && present_speed != 16'd0)) &&
                  ((drive_mode != scr_pkg::MODE_BACKWARD) || present_speed[15]))
    else $error("drive mode disagrees with speed");

endmodule

bind s_curve_speed_ramp_core scr_port_checker u_scr_port_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .present_speed (present_speed),
  .pwm_duty      (pwm_duty),
  .drive_mode    (drive_mode)
);
`default_nettype wire
